// ===== design/fwds_pkg.sv =====
// ----------------------------------------------------------------------------
// fwds_pkg
// shared types and codes for the fifo with directional search
// ----------------------------------------------------------------------------
package fwds_pkg;

    localparam int VALUE_W  = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 4;

    localparam logic [ACTION_W-1:0] ACT_PUSH        = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP         = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_SEARCH_HEAD = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SEARCH_TAIL = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

// ===== design/fwds_cell.sv =====
// ----------------------------------------------------------------------------
// fwds_cell
// one storage cell of the queue chain, loads a new word or takes its neighbor's
// ----------------------------------------------------------------------------
module fwds_cell (
    input  logic                              aclk,
    input  fwds_pkg::cell_ctrl_t              ctrl,
    input  logic signed [fwds_pkg::VALUE_W-1:0] shift_in,
    input  logic signed [fwds_pkg::VALUE_W-1:0] load_in,
    output logic signed [fwds_pkg::VALUE_W-1:0] data_out
);

    logic signed [fwds_pkg::VALUE_W-1:0] data_reg;
    logic signed [fwds_pkg::VALUE_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.load) begin
            data_next = load_in;
        end else if (ctrl.shift) begin
            data_next = shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

// ===== design/fifo_with_directional_search.sv =====
// ----------------------------------------------------------------------------
// fifo_with_directional_search
// bounded fifo of signed words with search from head or tail
// ----------------------------------------------------------------------------
// s_tuser carries the action (push, pop, search from head, search from tail),
// s_tdata the value to push or the key to look for. every input word gives
// exactly one result word: m_tuser is the status, m_tdata the popped value and
// the match position.
// the queue lives in a chain of DEPTH cells, cell 0 holding the head whenever
// no search runs. push writes the cell at the tail and pop shifts the chain by
// one; both results are registered on acceptance. a search rotates the occupied
// cells past cell 0, one cell per cycle, and compares there until every stored
// word (1 to DEPTH) has passed, then loads the output register; the chain is
// back in order when it ends. a search of an empty queue answers without a
// scan, like push and pop.
// one item is worked on at a time; a new word is taken once the result
// register is free or being read in the same cycle, so a stalled receiver
// holds off the input side. reset empties the queue and drops any pending
// result; cell contents are not cleared.
// ----------------------------------------------------------------------------
module fifo_with_directional_search #(
    parameter int DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value [31:0]
    input  logic [1:0]  s_tuser,   // action [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // popped_value [31:0], found_position [35:32], zero pad
    output logic [1:0]  m_tuser    // status [1:0]
);

    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (OCC_W > fwds_pkg::POS_W) ? OCC_W : fwds_pkg::POS_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic signed [fwds_pkg::VALUE_W-1:0] cell_q [DEPTH];

    logic                                state_reg, state_next;
    logic [OCC_W-1:0]                    occ_reg, occ_next;
    logic [OCC_W-1:0]                    cnt_reg, cnt_next;
    logic signed [fwds_pkg::VALUE_W-1:0] key_reg, key_next;
    logic                                back_reg, back_next;
    logic                                hit_reg, hit_next;
    logic [OCC_W-1:0]                    hit_idx_reg, hit_idx_next;
    logic                                m_valid_reg, m_valid_next;
    logic [fwds_pkg::STATUS_W-1:0]       m_status_reg, m_status_next;
    logic signed [fwds_pkg::VALUE_W-1:0] m_pop_reg, m_pop_next;
    logic [fwds_pkg::POS_W-1:0]          m_pos_reg, m_pos_next;

    logic             accept;
    logic             do_push;
    logic             do_rotate;
    logic             match;
    logic             take_hit;
    logic             scan_last;
    logic [OCC_W-1:0] f_idx;
    logic [OCC_W-1:0] f_pos;
    logic [IDX_W-1:0] f_pos_w;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign match     = (cell_q[0] == key_reg);
    assign take_hit  = match && (back_reg || !hit_reg);
    assign scan_last = (cnt_reg == occ_reg - OCC_W'(1));
    assign f_idx     = take_hit ? cnt_reg : hit_idx_reg;
    assign f_pos     = back_reg ? (occ_reg - OCC_W'(1) - f_idx) : f_idx;
    assign f_pos_w   = IDX_W'(f_pos);

    always_comb begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        cnt_next      = cnt_reg;
        key_next      = key_reg;
        back_next     = back_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_pop_next    = m_pop_reg;
        m_pos_next    = m_pos_reg;
        do_push       = 1'b0;
        do_rotate     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    m_pop_next = '0;
                    m_pos_next = '0;
                    case (s_tuser)
                        fwds_pkg::ACT_PUSH: begin
                            m_valid_next = 1'b1;
                            if (occ_reg == OCC_W'(DEPTH)) begin
                                m_status_next = fwds_pkg::ST_FULL;
                            end else begin
                                m_status_next = fwds_pkg::ST_OK;
                                do_push       = 1'b1;
                                occ_next      = occ_reg + OCC_W'(1);
                            end
                        end
                        fwds_pkg::ACT_POP: begin
                            m_valid_next = 1'b1;
                            if (occ_reg == '0) begin
                                m_status_next = fwds_pkg::ST_EMPTY;
                            end else begin
                                m_status_next = fwds_pkg::ST_OK;
                                m_pop_next    = cell_q[0];
                                do_rotate     = 1'b1;
                                occ_next      = occ_reg - OCC_W'(1);
                            end
                        end
                        default: begin
                            if (occ_reg == '0) begin
                                m_valid_next  = 1'b1;
                                m_status_next = fwds_pkg::ST_NOTFOUND;
                            end else begin
                                state_next = S_SCAN;
                                cnt_next   = '0;
                                key_next   = s_tdata;
                                back_next  = (s_tuser == fwds_pkg::ACT_SEARCH_TAIL);
                                hit_next   = 1'b0;
                            end
                        end
                    endcase
                end
            end
            S_SCAN: begin
                do_rotate = 1'b1;
                cnt_next  = cnt_reg + OCC_W'(1);
                if (take_hit) begin
                    hit_next     = 1'b1;
                    hit_idx_next = cnt_reg;
                end
                if (scan_last) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                    if (hit_reg || match) begin
                        m_status_next = fwds_pkg::ST_OK;
                        m_pos_next    = f_pos_w[fwds_pkg::POS_W-1:0];
                    end else begin
                        m_status_next = fwds_pkg::ST_NOTFOUND;
                        m_pos_next    = '0;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++) begin : g_cell
            fwds_pkg::cell_ctrl_t                ctrl;
            logic signed [fwds_pkg::VALUE_W-1:0] nbr;
            assign ctrl.shift = do_rotate;
            assign ctrl.load  = do_push && (occ_reg == OCC_W'(i));
            if (i == DEPTH - 1) begin : g_end
                assign nbr = cell_q[0];
            end else begin : g_mid
                assign nbr = (occ_reg == OCC_W'(i + 1)) ? cell_q[0] : cell_q[i+1];
            end
            fwds_cell u_cell (
                .aclk     (aclk),
                .ctrl     (ctrl),
                .shift_in (nbr),
                .load_in  (s_tdata),
                .data_out (cell_q[i])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg      <= key_next;
        back_reg     <= back_next;
        hit_idx_reg  <= hit_idx_next;
        m_status_reg <= m_status_next;
        m_pop_reg    <= m_pop_next;
        m_pos_reg    <= m_pos_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_status_reg;
    assign m_tdata  = {4'b0, m_pos_reg, m_pop_reg};

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(DEPTH))
        else $error("occupancy above depth");

    a_scan_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |-> occ_reg != '0 && !s_tready)
        else $error("scan on empty queue or input open during scan");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_status_reg != fwds_pkg::ST_OK |-> m_pop_reg == '0 && m_pos_reg == '0)
        else $error("failed result carries data");

    a_scan_holds_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_SCAN |=> occ_reg == $past(occ_reg))
        else $error("occupancy changed during scan");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for fifo_with_directional_search: a mirror queue
// predicts status, popped value and match position for every input word;
// directed cases cover empty, full, extreme values and duplicate keys, then
// random push/pop/search traffic runs with bursty input and a stalling output
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH = 16;

    typedef struct packed {
        logic [fwds_pkg::STATUS_W-1:0] status;
        logic [fwds_pkg::VALUE_W-1:0]  popped;
        logic [fwds_pkg::POS_W-1:0]    position;
    } outcome_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // value [31:0]
    logic [1:0]  s_tuser;   // action [1:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // popped_value [31:0], found_position [35:32], zero pad
    logic [1:0]  m_tuser;   // status [1:0]

    logic [fwds_pkg::VALUE_W-1:0] q_entries [DEPTH];
    int                           q_head;
    int                           q_count;
    outcome_t                     expected_results [$];
    int                           errors;
    int                           burst_left;

    fifo_with_directional_search #(
        .DEPTH(DEPTH)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic outcome_t predict_outcome(logic [fwds_pkg::ACTION_W-1:0] act,
                                                 logic [fwds_pkg::VALUE_W-1:0] val);
        outcome_t o;
        int       off;
        o = '0;
        o.status = fwds_pkg::ST_OK;
        case (act)
            fwds_pkg::ACT_PUSH: begin
                if (q_count >= DEPTH) begin
                    o.status = fwds_pkg::ST_FULL;
                end else begin
                    q_entries[(q_head + q_count) % DEPTH] = val;
                    q_count++;
                end
            end
            fwds_pkg::ACT_POP: begin
                if (q_count == 0) begin
                    o.status = fwds_pkg::ST_EMPTY;
                end else begin
                    o.popped = q_entries[q_head];
                    q_head = (q_head + 1) % DEPTH;
                    q_count--;
                end
            end
            default: begin
                o.status = fwds_pkg::ST_NOTFOUND;
                for (int i = 0; i < q_count; i++) begin
                    off = (act == fwds_pkg::ACT_SEARCH_HEAD) ? i : q_count - 1 - i;
                    if (q_entries[(q_head + off) % DEPTH] == val) begin
                        o.status = fwds_pkg::ST_OK;
                        o.position = i[fwds_pkg::POS_W-1:0];
                        break;
                    end
                end
            end
        endcase
        return o;
    endfunction

    // input side predicts first so a same-edge result always finds its entry
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_outcome(s_tuser, s_tdata));
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.popped = m_tdata[31:0];
                got.position = m_tdata[35:32];
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result word status %0d data %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status != want.status) begin
                        errors++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.popped != want.popped) begin
                        errors++;
                        $display("%0t: popped value expected %h got %h",
                                 $time, want.popped, got.popped);
                    end
                    if (got.position != want.position) begin
                        errors++;
                        $display("%0t: found position expected %0d got %0d",
                                 $time, want.position, got.position);
                    end
                end
            end
        end
    end

    // receiver: ready runs of random length broken by short stalls
    initial begin
        int run_len;
        int stall_len;
        m_tready = 1'b0;
        forever begin
            run_len = $urandom_range(1, 40);
            stall_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            @(negedge aclk) m_tready <= 1'b1;
            repeat (run_len - 1) @(negedge aclk);
            if (stall_len != 0) begin
                @(negedge aclk) m_tready <= 1'b0;
                repeat (stall_len - 1) @(negedge aclk);
            end
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(logic [fwds_pkg::ACTION_W-1:0] act,
                             logic [fwds_pkg::VALUE_W-1:0] val);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_tvalid <= 1'b1;
        s_tuser <= act;
        s_tdata <= val;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
        burst_left--;
    endtask

    function automatic logic [fwds_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 7) - 4;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7fff_ffff;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // mostly keys that are stored now, so searches hit at every depth
    function automatic logic [fwds_pkg::VALUE_W-1:0] pick_key();
        if (q_count > 0 && $urandom_range(0, 3) != 0) begin
            return q_entries[(q_head + $urandom_range(0, q_count - 1)) % DEPTH];
        end
        return random_value();
    endfunction

    task automatic test_empty_queue();
        send_word(fwds_pkg::ACT_POP, 32'h0000_0000);
        send_word(fwds_pkg::ACT_SEARCH_HEAD, 32'h0000_0000);
        send_word(fwds_pkg::ACT_SEARCH_TAIL, 32'hffff_ffff);
    endtask

    task automatic test_fill_to_full();
        send_word(fwds_pkg::ACT_PUSH, 32'h8000_0000);
        send_word(fwds_pkg::ACT_PUSH, 32'h7fff_ffff);
        send_word(fwds_pkg::ACT_PUSH, 32'h0000_0000);
        send_word(fwds_pkg::ACT_PUSH, 32'hffff_ffff);
        send_word(fwds_pkg::ACT_PUSH, 32'h0000_0005);
        for (int i = 0; i < 10; i++) begin
            send_word(fwds_pkg::ACT_PUSH, (i == 5) ? 32'h0000_0005 : 32'h0000_0100 + i);
        end
        send_word(fwds_pkg::ACT_PUSH, 32'h0000_0109);
        send_word(fwds_pkg::ACT_PUSH, 32'h0000_0042);
    endtask

    task automatic test_search_full();
        send_word(fwds_pkg::ACT_SEARCH_HEAD, 32'h0000_0109);
        send_word(fwds_pkg::ACT_SEARCH_TAIL, 32'h8000_0000);
        send_word(fwds_pkg::ACT_SEARCH_HEAD, 32'h0000_0005);
        send_word(fwds_pkg::ACT_SEARCH_TAIL, 32'h0000_0005);
        send_word(fwds_pkg::ACT_SEARCH_HEAD, 32'h0000_0042);
        send_word(fwds_pkg::ACT_SEARCH_TAIL, 32'h7fff_fffe);
    endtask

    task automatic test_random_traffic(int n_words);
        int push_pct;
        push_pct = 50;
        for (int k = 0; k < n_words; k++) begin
            if (k % 40 == 0) begin
                push_pct = $urandom_range(15, 85);
            end
            if ($urandom_range(0, 99) < 35) begin
                send_word($urandom_range(0, 1) ? fwds_pkg::ACT_SEARCH_HEAD
                                               : fwds_pkg::ACT_SEARCH_TAIL,
                          pick_key());
            end else if ($urandom_range(0, 99) < push_pct) begin
                send_word(fwds_pkg::ACT_PUSH, random_value());
            end else begin
                send_word(fwds_pkg::ACT_POP, $urandom);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = fwds_pkg::ACT_PUSH;
        errors = 0;
        burst_left = 0;
        q_head = 0;
        q_count = 0;
        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        test_empty_queue();
        test_fill_to_full();
        test_search_full();
        test_random_traffic(750);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (DEPTH + 8) @(negedge aclk);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
design/fwds_pkg.sv
design/fwds_cell.sv
design/fifo_with_directional_search.sv
tb/tb.sv
